### design/sobel_edge_magnitude_stream_top_macros.svh
// Assertion helpers shared by the checker.
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is active.
`define SEM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is active.
`define SEM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sem_pkg.sv
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 16;
    localparam int WID_W      = 11;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [WID_W-1:0] WIDTH_MIN    = 11'd3;
    localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
    localparam logic [ROW_W-1:0] HEIGHT_MIN   = 16'd3;
    localparam logic [PIX_W-1:0] EDGE_MAX     = 8'd255;

    typedef logic [8:0][PIX_W-1:0] t_window;

    // Decision taken for one input transaction at the moment it is accepted.
    typedef struct packed {
        logic             proc;
        logic             emit;
        logic             inner;
        logic             last;
        logic             top_en;
        logic             mid_en;
        logic [COL_W-1:0] col;
    } t_item_ctrl;

    // Column data of one item, in the cycle after its acceptance.
    typedef struct packed {
        logic             valid;
        logic             proc;
        logic             emit;
        logic             inner;
        logic             last;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] pixel;
    } t_col_data;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             frame_last;
    } t_result;

    function automatic logic [PIX_W-1:0] sobel_mag(input t_window w);
        logic signed [11:0] a, c, d2, f2, g, i, b2, h2;
        logic signed [11:0] gx, gy, ax, ay;
        logic [11:0]        m;
        a  = $signed({4'b0, w[0]});
        c  = $signed({4'b0, w[2]});
        d2 = $signed({3'b0, w[3], 1'b0});
        f2 = $signed({3'b0, w[5], 1'b0});
        g  = $signed({4'b0, w[6]});
        i  = $signed({4'b0, w[8]});
        b2 = $signed({3'b0, w[1], 1'b0});
        h2 = $signed({3'b0, w[7], 1'b0});
        gx = a - c + d2 - f2 + g - i;
        gy = a + b2 + c - g - h2 - i;
        ax = gx[11] ? -gx : gx;
        ay = gy[11] ? -gy : gy;
        m  = {1'b0, ax[10:0]} + {1'b0, ay[10:0]};
        return (m > {4'b0, EDGE_MAX}) ? EDGE_MAX : m[PIX_W-1:0];
    endfunction

endpackage

### design/sem_ctrl.sv
module sem_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_accept,
    input  logic                            i_cmd,
    output sem_pkg::t_item_ctrl             o_item
);

    logic [sem_pkg::WID_W-1:0] r_image_width;
    logic [sem_pkg::ROW_W-1:0] r_image_height;
    logic [sem_pkg::ROW_W-1:0] r_in_row,  n_in_row;
    logic [sem_pkg::COL_W-1:0] r_in_col,  n_in_col;
    logic [sem_pkg::ROW_W-1:0] r_out_row, n_out_row;
    logic [sem_pkg::COL_W-1:0] r_out_col, n_out_col;
    logic                      r_frame_received, n_frame_received;

    logic [sem_pkg::WID_W-1:0] w_eff;
    logic [sem_pkg::WID_W-1:0] w_m1_full, w_m2_full;
    logic [sem_pkg::COL_W-1:0] w_m1, w_m2;
    logic [sem_pkg::ROW_W-1:0] h_eff, h_m1, h_m2;
    logic                      ready_px;
    logic                      in_col_end, out_col_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sem_pkg::WIDTH_RESET;
            r_image_height <= sem_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sem_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[sem_pkg::WID_W-1:0];
                sem_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[sem_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_image_width < sem_pkg::WIDTH_MIN) begin
            w_eff = sem_pkg::WIDTH_MIN;
        end else if (r_image_width > sem_pkg::WIDTH_MAX) begin
            w_eff = sem_pkg::WIDTH_MAX;
        end else begin
            w_eff = r_image_width;
        end
        w_m1_full = w_eff - sem_pkg::WID_W'(1);
        w_m2_full = w_eff - sem_pkg::WID_W'(2);
        w_m1      = w_m1_full[sem_pkg::COL_W-1:0];
        w_m2      = w_m2_full[sem_pkg::COL_W-1:0];
        h_eff     = (r_image_height < sem_pkg::HEIGHT_MIN) ? sem_pkg::HEIGHT_MIN
                                                           : r_image_height;
        h_m1      = h_eff - sem_pkg::ROW_W'(1);
        h_m2      = h_eff - sem_pkg::ROW_W'(2);
    end

    always_comb begin
        ready_px     = (r_in_row >= sem_pkg::ROW_W'(2)) ||
                       ((r_in_row == sem_pkg::ROW_W'(1)) && (r_in_col != '0));
        in_col_end   = (r_in_col >= w_m1);
        out_col_end  = (r_out_col >= w_m1);

        o_item.proc   = (i_cmd == sem_pkg::CMD_PIXEL) && !r_frame_received;
        o_item.emit   = (i_cmd == sem_pkg::CMD_DRAIN) ? r_frame_received
                                                      : (o_item.proc && ready_px);
        // A drain result is always zero, even after the width changed in mid-frame.
        o_item.inner  = o_item.proc &&
                        (r_out_row != '0) && (r_out_row <= h_m2) &&
                        (r_out_col != '0) && (r_out_col <= w_m2);
        o_item.last   = out_col_end && (r_out_row >= h_m1);
        o_item.top_en = (r_in_row >= sem_pkg::ROW_W'(2));
        o_item.mid_en = (r_in_row != '0);
        o_item.col    = r_in_col;

        n_in_row         = r_in_row;
        n_in_col         = r_in_col;
        n_out_row        = r_out_row;
        n_out_col        = r_out_col;
        n_frame_received = r_frame_received;

        if (i_accept && o_item.proc) begin
            if (in_col_end) begin
                n_in_col = '0;
                if (r_in_row >= h_m1) begin
                    n_in_row         = '0;
                    n_frame_received = 1'b1;
                end else begin
                    n_in_row = r_in_row + sem_pkg::ROW_W'(1);
                end
            end else begin
                n_in_col = r_in_col + sem_pkg::COL_W'(1);
            end
        end

        // The frame's last result returns every position to the start.
        if (i_accept && o_item.emit) begin
            priority if (o_item.last) begin
                n_in_row         = '0;
                n_in_col         = '0;
                n_out_row        = '0;
                n_out_col        = '0;
                n_frame_received = 1'b0;
            end else if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + sem_pkg::ROW_W'(1);
            end else begin
                n_out_col = r_out_col + sem_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row         <= '0;
            r_in_col         <= '0;
            r_out_row        <= '0;
            r_out_col        <= '0;
            r_frame_received <= 1'b0;
        end else begin
            r_in_row         <= n_in_row;
            r_in_col         <= n_in_col;
            r_out_row        <= n_out_row;
            r_out_col        <= n_out_col;
            r_frame_received <= n_frame_received;
        end
    end

endmodule

### design/sem_line_buf.sv
module sem_line_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  sem_pkg::t_item_ctrl         i_item,
    input  logic [sem_pkg::PIX_W-1:0]   i_pixel,
    output sem_pkg::t_col_data          o_col
);

    logic [sem_pkg::PIX_W-1:0] r_older_mem [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] r_newer_mem [sem_pkg::MAX_WIDTH];
    logic [sem_pkg::PIX_W-1:0] r_older_q, r_newer_q;
    logic                      r_s1_valid;
    sem_pkg::t_item_ctrl       r_s1_item;
    logic [sem_pkg::PIX_W-1:0] r_s1_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_item  <= i_item;
            r_s1_pixel <= i_pixel;
        end
    end

    always_comb begin
        o_col.valid = r_s1_valid;
        o_col.proc  = r_s1_item.proc;
        o_col.emit  = r_s1_item.emit;
        o_col.inner = r_s1_item.inner;
        o_col.last  = r_s1_item.last;
        o_col.top   = r_s1_item.top_en ? r_older_q : '0;
        o_col.mid   = r_s1_item.mid_en ? r_newer_q : '0;
        o_col.pixel = r_s1_pixel;
    end

    // A column is written back the cycle after its read; the same column is
    // read again no sooner than a full row later, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_older_q <= r_older_mem[i_item.col];
            r_newer_q <= r_newer_mem[i_item.col];
        end
        if (r_s1_valid && r_s1_item.proc) begin
            r_older_mem[r_s1_item.col] <= o_col.mid;
            r_newer_mem[r_s1_item.col] <= r_s1_pixel;
        end
    end

endmodule

### design/sem_window.sv
module sem_window (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sem_pkg::t_col_data          i_col,
    output logic                        o_push,
    output sem_pkg::t_result            o_result
);

    sem_pkg::t_window r_window, n_window;
    logic             r_s2_valid;
    logic             r_s2_inner;
    logic             r_s2_last;

    always_comb begin
        n_window = r_window;
        if (i_col.valid && i_col.proc) begin
            for (int r = 0; r < 3; r++) begin
                n_window[r*3+0] = r_window[r*3+1];
                n_window[r*3+1] = r_window[r*3+2];
            end
            n_window[2] = i_col.top;
            n_window[5] = i_col.mid;
            n_window[8] = i_col.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_window   <= n_window;
            r_s2_valid <= i_col.valid && i_col.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_inner <= i_col.inner;
        r_s2_last  <= i_col.last;
    end

    assign o_push              = r_s2_valid;
    assign o_result.edge_value = r_s2_inner ? sem_pkg::sobel_mag(r_window) : '0;
    assign o_result.frame_last = r_s2_last;

endmodule

### design/sem_out_fifo.sv
module sem_out_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  sem_pkg::t_result            i_result,
    output logic                        o_valid,
    input  logic                        i_ready,
    output sem_pkg::t_result            o_result,
    output logic [sem_pkg::CNT_W-1:0]   o_count
);

    sem_pkg::t_result            r_mem [sem_pkg::FIFO_DEPTH];
    logic [sem_pkg::FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [sem_pkg::CNT_W-1:0]   r_count;
    logic                        pop;

    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];
    assign o_count  = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + sem_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + sem_pkg::FIFO_AW'(1);
            end
            r_count <= r_count + sem_pkg::CNT_W'(i_push) - sem_pkg::CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

endmodule

### design/sobel_edge_magnitude_stream_top.sv
// A result passes through the registered line-buffer stage, the window stage and the output
// queue before it is valid on o_m_axis_tdata and can be taken there.
// Throughput: one input transaction per cycle; input stalls only while the queue could overflow.
// Results lag pixels by image_width+1 pixels in the frame; drain items flush the rest.
// Reset (synchronous, active low) clears counters, window and output queue; line memories
// are not cleared and are only read where the current frame has written them.
module sobel_edge_magnitude_stream_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] pixel
    input  logic                            i_s_axis_tuser,   // [0] cmd
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [7:0]                      o_m_axis_tdata,   // [7:0] edge_value
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                       accept;
    sem_pkg::t_item_ctrl        item;
    sem_pkg::t_col_data         col;
    logic                       push;
    sem_pkg::t_result           result;
    sem_pkg::t_result           out_result;
    logic [sem_pkg::CNT_W-1:0]  fifo_count;
    logic [sem_pkg::CNT_W-1:0]  pending;

    // Every transaction in flight may still land in the queue, so it is counted.
    assign pending         = fifo_count + sem_pkg::CNT_W'(col.valid) + sem_pkg::CNT_W'(push);
    assign o_s_axis_tready = (pending < sem_pkg::CNT_W'(sem_pkg::FIFO_DEPTH));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    sem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (i_s_axis_tuser),
        .o_item      (item)
    );

    sem_line_buf u_line_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_pixel  (i_s_axis_tdata),
        .o_col    (col)
    );

    sem_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_col    (col),
        .o_push   (push),
        .o_result (result)
    );

    sem_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (result),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_result),
        .o_count  (fifo_count)
    );

    assign o_m_axis_tdata = out_result.edge_value;
    assign o_m_axis_tlast = out_result.frame_last;

endmodule

### design/sem_checker.sv
`include "sobel_edge_magnitude_stream_top_macros.svh"

module sem_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [7:0]                      o_m_axis_tdata,
    input logic                            o_m_axis_tlast
);

    logic in_xact;

    assign in_xact = i_s_axis_tvalid && o_s_axis_tready;

    // A new result on the output must trace back to an accepted input transaction.
    `SEM_ASSERT_IMPL(a_result_follows_input, i_clk, i_rst_n, $rose(o_m_axis_tvalid), $past(in_xact, 3), "result without a matching input transaction")

    // Input back-pressure only happens while results are waiting.
    `SEM_ASSERT_IMPL(a_stall_needs_backlog, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input stalled with no result pending")

    // A stalled result holds its value.
    `SEM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled result changed")

endmodule

bind sobel_edge_magnitude_stream_top sem_checker u_sem_checker (.*);
